/* hw/rtl/satsf_pkg.sv */
`timescale 1ns / 1ps
package satsf_pkg;

  localparam int unsigned SETS_DEF   = 8;
  localparam int unsigned WAYS_DEF   = 4;
  localparam int unsigned WORDS_DEF  = 2;
  localparam int unsigned TAG_W      = 6;
  localparam int unsigned ADDR_W     = 10;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_RES
  } state_t;

  // Reduce the 3-bit set field below n by repeated subtraction (n >= 2).
  function automatic logic [2:0] set_reduce(input logic [2:0] v, input int unsigned n);
    logic [2:0] r;
    r = v;
    for (int i = 0; i < 3; i++) begin
      if (32'(r) >= n) r = r - 3'(n);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/satsf_ram.sv */
`timescale 1ns / 1ps
module satsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/set_assoc_tag_store_fifo_unit.sv */
`timescale 1ns / 1ps
// Sequence: accept in ST_IDLE, then ST_READ and ST_CMP for each way scanned, then
// ST_RES loads the result; a hit stops the scan at its way, a miss scans all ways.
// Throughput: one item at a time; the way scan through the single tag RAM read
// port sets the rate. The next item is taken while a result waits on the output.
// Reset (rst, synchronous): all entries invalid, replacement pointers zero.
module set_assoc_tag_store_fifo_unit
  import satsf_pkg::*;
#(
  parameter int unsigned SETS           = SETS_DEF,
  parameter int unsigned WAYS           = WAYS_DEF,
  parameter int unsigned WORDS_PER_LINE = WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [0] opcode, [10:1] address, [15:11] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] hit, [2:1] way, [3] evicted, [9:4] evicted_tag, [15:10] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned SET_W  = $clog2(SETS);
  localparam int unsigned WAY_W  = $clog2(WAYS);
  localparam int unsigned WORD_W = (WORDS_PER_LINE > 1) ? 1 : 0;
  localparam int unsigned SLOT_W = SET_W + WORD_W;
  localparam int unsigned ENT_W  = SLOT_W + WAY_W;
  localparam int unsigned N_ENT  = 1 << ENT_W;
  localparam int unsigned N_SLOT = 1 << SLOT_W;

  state_t state, state_next;

  logic             op_q;
  logic [TAG_W-1:0] tag_q;
  logic [SLOT_W-1:0] slot_q;
  logic [WAY_W-1:0] idx;
  logic             have_free;
  logic [WAY_W-1:0] first_free;
  logic [TAG_W-1:0] vtag;

  logic [N_ENT-1:0] valid;
  logic [WAY_W-1:0] fifo_ptr [N_SLOT];

  logic             res_hit;
  logic [1:0]       res_way;
  logic             res_evicted;
  logic [TAG_W-1:0] res_etag;

  logic             out_hit;
  logic [1:0]       out_way;
  logic             out_evicted;
  logic [TAG_W-1:0] out_etag;

  logic [ADDR_W-1:0] in_addr;
  logic [SET_W-1:0]  set_c;
  logic [SLOT_W-1:0] slot_c;
  logic              in_xfer;

  logic [TAG_W-1:0] rd_data;
  logic             ram_re;
  logic             ram_we;
  logic [ENT_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_waddr;

  logic             cur_valid;
  logic             cur_match;
  logic             last_way;
  logic             done;
  logic             ins;
  logic             full;
  logic [WAY_W-1:0] ptr;
  logic [WAY_W-1:0] wway;
  logic [TAG_W-1:0] victim_tag;
  logic             out_free;

  assign in_addr = s_axis_tdata[ADDR_W:1];
  assign set_c   = SET_W'(set_reduce(in_addr[3:1], SETS));

  always_comb begin
    if (WORDS_PER_LINE > 1) slot_c = SLOT_W'({set_c, in_addr[0]});
    else slot_c = SLOT_W'(set_c);
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  satsf_ram #(
    .WIDTH (TAG_W),
    .DEPTH (N_ENT)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tag_q),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // compare of the way read in the previous cycle
  assign cur_valid  = valid[{slot_q, idx}];
  assign cur_match  = cur_valid && (rd_data == tag_q);
  assign last_way   = (idx == WAY_W'(WAYS - 1));
  assign ptr        = fifo_ptr[slot_q];
  assign full       = !have_free && cur_valid;
  assign victim_tag = (idx == ptr) ? rd_data : vtag;

  always_comb begin
    if (full) wway = ptr;
    else if (have_free) wway = first_free;
    else wway = idx;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_xfer) state_next = ST_READ;
      ST_READ: state_next = ST_CMP;
      ST_CMP: begin
        if (cur_match || last_way) state_next = ST_RES;
        else state_next = ST_READ;
      end
      ST_RES: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_re    = (state == ST_READ);
    ram_raddr = {slot_q, idx};
    done      = (state == ST_CMP) && (cur_match || last_way);
    ins       = (state == ST_CMP) && last_way && !cur_match && (op_q == OP_INSERT);
    ram_we    = ins;
    ram_waddr = {slot_q, wway};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      valid         <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < N_SLOT; i++) fifo_ptr[i] <= '0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        op_q      <= s_axis_tdata[0];
        tag_q     <= in_addr[ADDR_W-1:4];
        slot_q    <= slot_c;
        idx       <= '0;
        have_free <= 1'b0;
      end
      if (state == ST_CMP && !done) begin
        idx <= idx + 1'b1;
        if (!cur_valid && !have_free) begin
          have_free  <= 1'b1;
          first_free <= idx;
        end
        if (idx == ptr) vtag <= rd_data;
      end
      if (done) begin
        res_hit     <= cur_match;
        res_way     <= cur_match ? 2'(idx) : (ins ? 2'(wway) : 2'b0);
        res_evicted <= ins && full;
        res_etag    <= (ins && full) ? victim_tag : '0;
      end
      if (ins) begin
        valid[{slot_q, wway}] <= 1'b1;
        // advance the replacement pointer on eviction only
        if (full) fifo_ptr[slot_q] <= (ptr == WAY_W'(WAYS - 1)) ? '0 : ptr + 1'b1;
      end
      if (state == ST_RES && out_free) begin
        m_axis_tvalid <= 1'b1;
        out_hit       <= res_hit;
        out_way       <= res_way;
        out_evicted   <= res_evicted;
        out_etag      <= res_etag;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W - TAG_W - 4)'(0), out_etag, out_evicted, out_way, out_hit};

endmodule
